// File: rtl/hfaq_pkg.sv
// Shared types and constants for the height field altitude query core.
package hfaq_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_LINES   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_SCALE      = 4'd3;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_z;
		logic        [7:0]  write_line;
		logic        [7:0]  write_column;
		logic signed [15:0] write_height;
	} req_t;

	typedef struct packed {
		logic signed [15:0] altitude;
		logic               inside_res;
	} res_t;

	// Which bank parity feeds each corner sample, plus the fraction pair.
	typedef struct packed {
		logic        x0p;
		logic        x1p;
		logic        z0p;
		logic        z1p;
		logic [15:0] fx;
		logic [15:0] fz;
		logic        on_grid;
	} sel_t;

endpackage

// File: rtl/hfaq_bank.sv
// One parity bank of the height store: one write and one registered read per cycle.
module hfaq_bank #(
	parameter int ADDR_W = 14,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/hfaq_interp.sv
// Triangle interpolation pipeline, rounding, saturation and the result register.
module hfaq_interp #(
	parameter int HB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  hfaq_pkg::sel_t       sel,
	input  logic signed [HB-1:0] rdata [4],
	output logic                 take,
	input  logic                 res_stall,
	output logic                 res_valid,
	output hfaq_pkg::res_t       res_item
);

	import hfaq_pkg::*;

	localparam int DW = HB + 1;
	localparam int PW = HB + 18;
	localparam int AW = HB + 20;

	logic v_s3, v_s4, v_s5, res_valid_q;
	logic rdy_o, rdy5, rdy4, rdy3;

	sel_t sel_s3;

	logic signed [HB-1:0] y0, y1, y2, y3;
	logic signed [DW-1:0] a_c, b_c;
	logic                 gt;

	logic signed [DW-1:0] a_s4, b_s4;
	logic signed [HB-1:0] y0_s4, y0_s5;
	logic        [15:0]   fx_s4, fz_s4;
	logic                 inside_s4, inside_s5;

	logic signed [PW-1:0] p1_c, p2_c, p1_s5, p2_s5;
	logic signed [AW-1:0] acc, q;
	logic signed [15:0]   alt_c;
	res_t                 res_q;

	assign rdy_o = !res_valid_q || !res_stall;
	assign rdy5  = !v_s5 || rdy_o;
	assign rdy4  = !v_s4 || rdy5;
	assign rdy3  = !v_s3 || rdy4;
	assign take  = rdy3;

	// Corner samples come from the bank whose parity matches each coordinate.
	always_comb begin
		y0 = rdata[{sel_s3.z0p, sel_s3.x0p}];
		y1 = rdata[{sel_s3.z0p, sel_s3.x1p}];
		y2 = rdata[{sel_s3.z1p, sel_s3.x0p}];
		y3 = rdata[{sel_s3.z1p, sel_s3.x1p}];
		gt = sel_s3.fx > sel_s3.fz;
		if (gt) begin
			a_c = DW'(y1) - DW'(y0);
			b_c = DW'(y3) - DW'(y1);
		end else begin
			a_c = DW'(y3) - DW'(y2);
			b_c = DW'(y2) - DW'(y0);
		end
	end

	assign p1_c = PW'($signed({1'b0, fx_s4})) * PW'(a_s4);
	assign p2_c = PW'($signed({1'b0, fz_s4})) * PW'(b_s4);

	// The arithmetic shift floors, which with the half offset rounds half up.
	always_comb begin
		acc = (AW'(y0_s5) <<< 16) + AW'(p1_s5) + AW'(p2_s5) + AW'(32768);
		q   = acc >>> 16;
		if (q > AW'(32767)) begin
			alt_c = 16'sd32767;
		end else if (q < AW'(-32768)) begin
			alt_c = -16'sd32768;
		end else begin
			alt_c = q[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy3) begin
				v_s3 <= q_valid;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
			if (rdy_o) begin
				res_valid_q <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			sel_s3 <= sel;
		end
		if (rdy4) begin
			a_s4      <= a_c;
			b_s4      <= b_c;
			y0_s4     <= y0;
			fx_s4     <= sel_s3.fx;
			fz_s4     <= sel_s3.fz;
			inside_s4 <= sel_s3.on_grid;
		end
		if (rdy5) begin
			p1_s5     <= p1_c;
			p2_s5     <= p2_c;
			y0_s5     <= y0_s4;
			inside_s5 <= inside_s4;
		end
		if (rdy_o) begin
			res_q.altitude   <= inside_s5 ? alt_c : 16'sd0;
			res_q.inside_res <= inside_s5;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

// File: rtl/height_field_altitude_query_core.sv
// Top level: configuration, axis mapping stages, parity-banked height store, interpolation.
// A query's result passes the scale, grid index, bank read, difference, product and result registers; a stall holds it.
// Throughput: one request per cycle while req_stall is low; all four corner samples come from four parity banks
// read in the same cycle, and a write uses the same stage, so no accesses overlap.
// Writes produce no result. Reset clears the pipeline valids and sets the configuration
// registers to a 256 by 256 grid at unit scale; the height store holds no value until written.
module height_field_altitude_query_core #(
	parameter int MAX_LINES   = 256,
	parameter int MAX_COLUMNS = 256,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  hfaq_pkg::req_t                      req_item,
	output logic                                res_valid,
	input  logic                                res_stall,
	output hfaq_pkg::res_t                      res_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hfaq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hfaq_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import hfaq_pkg::*;

	localparam int HB  = HEIGHT_BITS;
	localparam int LW  = $clog2(MAX_LINES);
	localparam int CW  = $clog2(MAX_COLUMNS);
	localparam int HL  = (MAX_LINES + 1) / 2;
	localparam int HC  = (MAX_COLUMNS + 1) / 2;
	localparam int LHW = (HL > 1) ? $clog2(HL) : 1;
	localparam int CHW = (HC > 1) ? $clog2(HC) : 1;
	localparam int BAW = LHW + CHW;

	// Configuration registers.
	logic [8:0]  grid_lines_q, grid_columns_q;
	logic [23:0] x_scale_q, z_scale_q;
	logic [8:0]  lines, cols;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_lines_q   <= 9'd256;
			grid_columns_q <= 9'd256;
			x_scale_q      <= 24'h010000;
			z_scale_q      <= 24'h010000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GRID_LINES:   grid_lines_q   <= cfg_data[8:0];
				CFG_GRID_COLUMNS: grid_columns_q <= cfg_data[8:0];
				CFG_X_SCALE:      x_scale_q      <= cfg_data;
				CFG_Z_SCALE:      z_scale_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lines = (32'(grid_lines_q) < MAX_LINES) ? grid_lines_q : 9'(MAX_LINES);
	assign cols  = (32'(grid_columns_q) < MAX_COLUMNS) ? grid_columns_q : 9'(MAX_COLUMNS);

	// Stage 1: scale products.
	logic                 v_s1, mode_s1;
	logic signed [56:0]   prodx_s1, prodz_s1;
	logic        [7:0]    wline_s1, wcol_s1;
	logic signed [HB-1:0] wh_s1;

	// Stage 2: grid index and fraction.
	logic                 v_s2, mode_s2, inside_s2;
	logic        [LW-1:0] xi_s2;
	logic        [CW-1:0] zi_s2;
	logic        [15:0]   fx_s2, fz_s2;
	logic        [7:0]    wline_s2, wcol_s2;
	logic signed [HB-1:0] wh_s2;

	logic ready1, ready2, take3;

	logic signed [56:0] prodx_c, prodz_c, tx, tz;
	logic               inx, inz;

	assign prodx_c = 57'(req_item.pos_x) * 57'($signed({1'b0, x_scale_q}));
	assign prodz_c = 57'(req_item.pos_z) * 57'($signed({1'b0, z_scale_q}));

	// Adding count/2 in Q.32 centers the grid; floor is the top bits of t.
	assign tx  = prodx_s1 + $signed({17'd0, lines, 31'd0});
	assign tz  = prodz_s1 + $signed({17'd0, cols, 31'd0});
	assign inx = !tx[56] && (tx[55:32] < 24'(lines));
	assign inz = !tz[56] && (tz[55:32] < 24'(cols));

	assign ready2    = !v_s2 || (mode_s2 == MODE_WRITE) || take3;
	assign ready1    = !v_s1 || ready2;
	assign req_stall = !ready1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready1) begin
				v_s1 <= req_valid;
			end
			if (ready2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready1) begin
			mode_s1  <= req_item.mode;
			prodx_s1 <= prodx_c;
			prodz_s1 <= prodz_c;
			wline_s1 <= req_item.write_line;
			wcol_s1  <= req_item.write_column;
			// Heights narrower than the field are zero-extended, wider ones keep their low bits.
			wh_s1    <= HB'(req_item.write_height[15:0]);
		end
		if (ready2) begin
			mode_s2   <= mode_s1;
			inside_s2 <= inx && inz;
			xi_s2     <= tx[32 +: LW];
			zi_s2     <= tz[32 +: CW];
			fx_s2     <= tx[31:16];
			fz_s2     <= tz[31:16];
			wline_s2  <= wline_s1;
			wcol_s2   <= wcol_s1;
			wh_s2     <= wh_s1;
		end
	end

	// Bank addressing: index [0] is the even bank row, [1] the odd one.
	logic [LHW-1:0] xh [2];
	logic [CHW-1:0] zh [2];
	logic [LW:0]    xe1;
	logic [CW:0]    ze1;
	logic           clamp_x, clamp_z;
	logic           wr_ok, q_valid;
	logic [BAW-1:0] wr_addr;
	sel_t           sel;

	always_comb begin
		xe1   = {1'b0, xi_s2} + 1'b1;
		ze1   = {1'b0, zi_s2} + 1'b1;
		xh[1] = LHW'(xi_s2 >> 1);
		zh[1] = CHW'(zi_s2 >> 1);
		// The even row after the last line may not exist; its data is then unused.
		if (32'(xe1 >> 1) > HL - 1) begin
			xh[0] = LHW'(HL - 1);
		end else begin
			xh[0] = LHW'(xe1 >> 1);
		end
		if (32'(ze1 >> 1) > HC - 1) begin
			zh[0] = CHW'(HC - 1);
		end else begin
			zh[0] = CHW'(ze1 >> 1);
		end
		clamp_x = 32'(xe1) >= 32'(lines);
		clamp_z = 32'(ze1) >= 32'(cols);
	end

	always_comb begin
		sel.x0p     = xi_s2[0];
		sel.x1p     = clamp_x ? xi_s2[0] : !xi_s2[0];
		sel.z0p     = zi_s2[0];
		sel.z1p     = clamp_z ? zi_s2[0] : !zi_s2[0];
		sel.fx      = fx_s2;
		sel.fz      = fz_s2;
		sel.on_grid = inside_s2;
	end

	assign q_valid = v_s2 && (mode_s2 == MODE_QUERY);
	assign wr_ok   = v_s2 && (mode_s2 == MODE_WRITE) &&
	                 (32'(wline_s2) < MAX_LINES) && (32'(wcol_s2) < MAX_COLUMNS);
	assign wr_addr = {CHW'(wcol_s2 >> 1), LHW'(wline_s2 >> 1)};

	logic signed [HB-1:0] rdata [4];

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [HB-1:0] rd;

		hfaq_bank #(
			.ADDR_W(BAW),
			.DATA_W(HB)
		) u_bank (
			.clk    (clk),
			.wr_en  (wr_ok && (wline_s2[0] == b[0]) && (wcol_s2[0] == b[1])),
			.wr_addr(wr_addr),
			.wr_data(wh_s2),
			.rd_en  (q_valid && take3),
			.rd_addr({zh[b >> 1], xh[b % 2]}),
			.rd_data(rd)
		);

		assign rdata[b] = $signed(rd);
	end

	hfaq_interp #(
		.HB(HB)
	) u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.sel      (sel),
		.rdata    (rdata),
		.take     (take3),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res_item (res_item)
	);

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the height field altitude query core.
module testbench;
	import hfaq_pkg::*;

	localparam int GRID_MAX = 256;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 118;
	localparam int SETTLE_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd9;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register copies shared by the predictor and the request generator.
	logic [8:0] reg_lines = 9'd256;
	logic [8:0] reg_columns = 9'd256;
	logic [23:0] reg_x_scale = 24'd65536;
	logic [23:0] reg_z_scale = 24'd65536;

	logic signed [15:0] model_heights [0:GRID_MAX*GRID_MAX-1];
	bit height_known [0:GRID_MAX*GRID_MAX-1];
	req_t request_queue [$];
	res_t altitude_due [$];
	int unsigned pushed_count = 0;
	int unsigned accepted_count = 0;
	int unsigned error_count = 0;
	int unsigned cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	height_field_altitude_query_core #(
		.MAX_LINES(GRID_MAX),
		.MAX_COLUMNS(GRID_MAX),
		.HEIGHT_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int in_use(input logic [8:0] count_reg);
		return (count_reg < GRID_MAX) ? int'(count_reg) : GRID_MAX;
	endfunction

	// Maps one axis to a grid index and a Q0.16 fraction; returns 0 when off the grid.
	function automatic bit map_axis(input logic signed [31:0] pos, input logic [23:0] scale,
			input int count, output int idx, output logic [15:0] frac);
		longint t;
		idx = 0;
		frac = '0;
		if (count == 0)
			return 1'b0;
		t = longint'(pos) * longint'({40'd0, scale}) + (longint'(count) <<< 31);
		if (t < 0)
			return 1'b0;
		if ((t >>> 32) >= count)
			return 1'b0;
		idx = int'(t >>> 32);
		frac = t[31:16];
		return 1'b1;
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endtask

	task automatic track_request(input req_t it);
		int nl, nc, xi, zi, xn, zn;
		logic [15:0] fx, fz;
		longint y0, y1, y2, y3, acc;
		res_t r;
		if (it.mode == MODE_WRITE) begin
			model_heights[{it.write_column, it.write_line}] = it.write_height;
			return;
		end
		nl = in_use(reg_lines);
		nc = in_use(reg_columns);
		r = '0;
		if (map_axis(it.pos_x, reg_x_scale, nl, xi, fx) &&
				map_axis(it.pos_z, reg_z_scale, nc, zi, fz)) begin
			xn = (xi + 1 < nl) ? xi + 1 : nl - 1;
			zn = (zi + 1 < nc) ? zi + 1 : nc - 1;
			y0 = model_heights[xi + zi * GRID_MAX];
			y1 = model_heights[xn + zi * GRID_MAX];
			y2 = model_heights[xi + zn * GRID_MAX];
			y3 = model_heights[xn + zn * GRID_MAX];
			acc = y0 <<< 16;
			if (fx > fz)
				acc += longint'(fx) * (y1 - y0) + longint'(fz) * (y3 - y1);
			else
				acc += longint'(fx) * (y3 - y2) + longint'(fz) * (y2 - y0);
			acc = (acc + 32768) >>> 16;
			if (acc > 32767)
				acc = 32767;
			if (acc < -32768)
				acc = -32768;
			r.altitude = acc[15:0];
			r.inside_res = 1'b1;
		end
		altitude_due.push_back(r);
	endtask

	task automatic push_request(input req_t it);
		request_queue.push_back(it);
		pushed_count++;
	endtask

	task automatic store_height(input int line, input int col, input logic signed [15:0] h);
		req_t it;
		it.mode = MODE_WRITE;
		it.pos_x = $urandom;
		it.pos_z = $urandom;
		it.write_line = line[7:0];
		it.write_column = col[7:0];
		it.write_height = h;
		height_known[line + col * GRID_MAX] = 1'b1;
		push_request(it);
	endtask

	task automatic need_height(input int line, input int col);
		if (!height_known[line + col * GRID_MAX])
			store_height(line, col, 16'($urandom));
	endtask

	// Queues a query, first writing any corner sample it would read that was never stored.
	task automatic add_query(input logic signed [31:0] px, input logic signed [31:0] pz);
		int nl, nc, xi, zi, xn, zn;
		logic [15:0] fx, fz;
		req_t it;
		nl = in_use(reg_lines);
		nc = in_use(reg_columns);
		if (map_axis(px, reg_x_scale, nl, xi, fx) && map_axis(pz, reg_z_scale, nc, zi, fz)) begin
			xn = (xi + 1 < nl) ? xi + 1 : nl - 1;
			zn = (zi + 1 < nc) ? zi + 1 : nc - 1;
			need_height(xi, zi);
			need_height(xn, zi);
			need_height(xi, zn);
			need_height(xn, zn);
		end
		it.mode = MODE_QUERY;
		it.pos_x = px;
		it.pos_z = pz;
		it.write_line = 8'($urandom_range(255));
		it.write_column = 8'($urandom_range(255));
		it.write_height = 16'($urandom);
		push_request(it);
	endtask

	// Picks a world position that usually lands near a chosen grid coordinate on one axis.
	function automatic logic signed [31:0] aim_axis(input logic [23:0] scale, input int count,
			input logic [31:0] shared);
		longint target, p;
		int idx, r;
		logic [31:0] frac;
		r = $urandom_range(99);
		if (r < 6)
			return $urandom;
		frac = ($urandom_range(3) == 0) ? 32'd0 : (($urandom_range(1) == 1) ? shared : $urandom);
		if (r < 14)
			idx = ($urandom_range(1) == 1) ? -1 : count;
		else if (r < 28)
			idx = count - 1;
		else if (r < 68)
			idx = $urandom_range(((count < 6) ? count : 6) - 1);
		else
			idx = $urandom_range(count - 1);
		target = (longint'(idx) <<< 32) + longint'({32'd0, frac});
		p = (target - (longint'(count) <<< 31)) / longint'({40'd0, scale});
		if (p != longint'($signed(p[31:0])))
			return $urandom;
		return p[31:0];
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_GRID_LINES: reg_lines = data[8:0];
			CFG_GRID_COLUMNS: reg_columns = data[8:0];
			CFG_X_SCALE: reg_x_scale = data;
			CFG_Z_SCALE: reg_z_scale = data;
			default: ;
		endcase
	endtask

	task automatic set_grid(input int lines, input int cols, input logic [23:0] xs,
			input logic [23:0] zs);
		write_reg(CFG_GRID_LINES, 24'(lines));
		write_reg(CFG_GRID_COLUMNS, 24'(cols));
		write_reg(CFG_X_SCALE, xs);
		write_reg(CFG_Z_SCALE, zs);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Request driver: a stalled request holds; otherwise the next one goes out unless resting.
	always @(posedge clk) begin
		bit rest;
		rest = ((cycles % 160) >= 30) && ($urandom_range(99) < send_idle_pct);
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				track_request(req_item);
				accepted_count++;
			end
			if (!req_valid || !req_stall) begin
				if (request_queue.size() != 0 && !rest) begin
					req_item <= request_queue.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (altitude_due.size() == 0) begin
					flag_error($sformatf("unexpected result: alt=%0d inside=%0b",
						res_item.altitude, res_item.inside_res));
				end else begin
					want = altitude_due.pop_front();
					if (res_item.altitude !== want.altitude ||
							res_item.inside_res !== want.inside_res)
						flag_error($sformatf(
							"altitude mismatch: expected alt=%0d inside=%0b, got alt=%0d inside=%0b",
							want.altitude, want.inside_res, res_item.altitude,
							res_item.inside_res));
				end
			end
			res_stall <= ((cycles % 160) >= 30) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		logic signed [31:0] lo;
		logic [31:0] shared;
		int phase_start;
		lo = -32'sd8388608;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				while (accepted_count != pushed_count || altitude_due.size() != 0)
					@(posedge clk);
				// Writes leave no result, so give the pipeline time to retire them.
				repeat (SETTLE_CYCLES) @(posedge clk);
				case (ph)
					1: begin
						set_grid(2, 2, 24'hFFFFFF, 24'd1);
						write_reg(CFG_UNUSED_IDX, 24'hABCDEF);
					end
					2: set_grid(256, 2, 24'd1, 24'd196608);
					3: set_grid(17, 200, 24'd12345, 24'd400000);
					4: set_grid(2, 256, 24'd65536, 24'hFFFFFF);
					5: set_grid(256, 256, 24'd32768, 24'd131072);
					6: set_grid(100, 3, 24'd700000, 24'd65536);
					default: set_grid(256, 256, 24'd65536, 24'd65536);
				endcase
				cfg_valid <= 1'b0;
			end
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 79;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 79;
				end
				default: begin
					send_idle_pct = 28;
					recv_stall_pct = 28;
				end
			endcase
			phase_start = pushed_count;
			if (ph == 0) begin
				// With the reset grid, world zero maps to sample 128 on both axes.
				store_height(0, 0, 16'sh8000);
				store_height(1, 0, 16'sh7FFF);
				store_height(0, 1, 16'sh7FFF);
				store_height(1, 1, 16'sh8000);
				store_height(255, 0, 16'sh5A5A);
				store_height(0, 255, 16'shA5A5);
				add_query(lo, lo);
				add_query(lo + 32'sh0000C000, lo + 32'sh00004000);
				add_query(lo + 32'sh00004000, lo + 32'sh0000C000);
				add_query(lo + 32'sh00008000, lo + 32'sh00008000);
				add_query(lo + 32'sh0000FFFF, lo + 32'sh00000001);
				// Last line and column: every neighbor read clamps onto the corner.
				add_query(32'sh007FFFFF, 32'sh007FFFFF);
				add_query(32'sh00800000, 32'sh00000000);
				add_query(32'sh00000000, 32'sh00800000);
				add_query(lo - 32'sd1, 32'sh00000000);
				add_query(32'sh00000000, lo - 32'sd1);
				add_query(32'sh80000000, 32'sh7FFFFFFF);
				add_query(32'sh00000000, 32'sh00000000);
			end
			while (pushed_count - phase_start < ITEMS_PER_PHASE) begin
				if ($urandom_range(99) < 15) begin
					store_height($urandom_range(255), $urandom_range(255), 16'($urandom));
				end else begin
					shared = $urandom;
					add_query(aim_axis(reg_x_scale, in_use(reg_lines), shared),
						aim_axis(reg_z_scale, in_use(reg_columns), shared));
				end
			end
		end
		while (accepted_count != pushed_count || altitude_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
